FILE: hdl/mtf_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Move-to-front rank package
// Shared types and constants for the move-to-front cell chain.
// ---------------------------------------------------------------------------
package mtf_pkg;

	localparam int ITEM_W = 9;
	localparam int RANK_W = 8;
	localparam int RANK_MAX = 255;
	localparam logic [ITEM_W-1:0] ITEM_COUNT_RST = 9'd256;

	localparam logic MODE_ACCESS = 1'b0;
	localparam logic MODE_RESTART = 1'b1;

	// control flags of an item travelling down the chain
	typedef struct packed {
		logic valid;
		logic restart;
		logic bad;
		logic found;
	} mtf_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/mtf_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Move-to-front list cell
// Holds one list entry; swaps it with the value passed down until the key
// is met, then marks the item found with this cell's position as rank.
// ---------------------------------------------------------------------------
module mtf_cell #(
	parameter int IDX_W = 8,
	parameter int unsigned POS = 0
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       adv,
	input  wire mtf_pkg::mtf_ctl_t          ctl_i,
	input  wire logic [IDX_W-1:0]           key_i,
	input  wire logic [IDX_W-1:0]           carry_i,
	input  wire logic [mtf_pkg::RANK_W-1:0] rank_i,
	output mtf_pkg::mtf_ctl_t               ctl_o,
	output logic [IDX_W-1:0]                key_o,
	output logic [IDX_W-1:0]                carry_o,
	output logic [mtf_pkg::RANK_W-1:0]      rank_o
);
	import mtf_pkg::*;

	localparam logic [IDX_W-1:0] POS_VAL = IDX_W'(POS);
	localparam logic [RANK_W-1:0] RANK_VAL =
		(POS > RANK_MAX) ? RANK_W'(RANK_MAX) : RANK_W'(POS);

	logic [IDX_W-1:0]  val_q, val_d;
	mtf_ctl_t          ctl_q, ctl_d;
	logic [IDX_W-1:0]  key_q, carry_q, carry_d;
	logic [RANK_W-1:0] rank_q, rank_d;

	always_comb begin
		val_d   = val_q;
		ctl_d   = ctl_i;
		carry_d = carry_i;
		rank_d  = rank_i;
		if (ctl_i.valid) begin
			if (ctl_i.restart) begin
				val_d = POS_VAL;
			end else if (!ctl_i.bad && !ctl_i.found) begin
				// take the value from ahead, hand ours down
				val_d   = carry_i;
				carry_d = val_q;
				if (val_q == key_i) begin
					ctl_d.found = 1'b1;
					rank_d      = RANK_VAL;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= POS_VAL;
			ctl_q <= '0;
		end else if (adv) begin
			val_q <= val_d;
			ctl_q <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_q   <= key_i;
			carry_q <= carry_d;
			rank_q  <= rank_d;
		end
	end

	assign ctl_o   = ctl_q;
	assign key_o   = key_q;
	assign carry_o = carry_q;
	assign rank_o  = rank_q;

endmodule
`default_nettype wire

FILE: hdl/move_to_front_rank.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Move-to-front rank
// Ordered list of items with rank report and move to front, built as a
// chain of list cells through which each item travels as a wavefront.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries mode and item. Mode access
//   reports how many items stand ahead of item and moves it to the front;
//   mode restart restores ascending order and yields no result.
//   Output channel (out_valid/out_ready) carries rank and bad_item.
//   Configuration channel (cfg_valid/cfg_ready) writes item_count; it is
//   always ready; the user must write it only while the block is idle,
//   which the block itself does not enforce.
// Pipeline:
//   An accepted item passes through cell 0 to cell MAX_ITEMS-1 and then
//   the output register. One item is taken every cycle while the output
//   does not stall; each item occupies one cell at a time, so successive
//   items follow one another down the chain without disturbing each other.
// Reset:
//   arst_n clears the chain and output register; the list returns to
//   ascending order and item_count to 256.
// Stall:
//   While a result waits and out_ready is low the whole chain holds and
//   in_ready drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module move_to_front_rank #(
	parameter int MAX_ITEMS = 256
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       mode,
	input  wire logic [mtf_pkg::ITEM_W-1:0] item,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [mtf_pkg::RANK_W-1:0]      rank,
	output logic                            bad_item,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [mtf_pkg::ITEM_W-1:0] item_count
);
	import mtf_pkg::*;

	localparam int IDX_W = $clog2(MAX_ITEMS);

	logic [ITEM_W-1:0] item_count_q;
	logic              adv;
	logic              bad;
	logic [31:0]       key_full;

	mtf_ctl_t          ctl_w   [MAX_ITEMS+1];
	logic [IDX_W-1:0]  key_w   [MAX_ITEMS+1];
	logic [IDX_W-1:0]  carry_w [MAX_ITEMS+1];
	logic [RANK_W-1:0] rank_w  [MAX_ITEMS+1];

	logic              out_valid_q;
	logic [RANK_W-1:0] rank_q;
	logic              bad_q;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_count_q <= ITEM_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			item_count_q <= item_count;
		end
	end

	// advance the whole chain unless a result is held at the output
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// classify the item at entry: zero, above the count or above capacity
	assign bad = (item == '0) || (item > item_count_q) ||
		(32'(item) > 32'(MAX_ITEMS));
	assign key_full = 32'(item) - 32'd1;

	// head of the chain: cell 0 takes the key itself as the value from ahead
	always_comb begin
		ctl_w[0].valid   = in_valid;
		ctl_w[0].restart = (mode == MODE_RESTART);
		ctl_w[0].bad     = bad;
		ctl_w[0].found   = 1'b0;
	end
	assign key_w[0]   = key_full[IDX_W-1:0];
	assign carry_w[0] = key_full[IDX_W-1:0];
	assign rank_w[0]  = '0;

	for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
		mtf_cell #(
			.IDX_W (IDX_W),
			.POS   (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.ctl_i   (ctl_w[k]),
			.key_i   (key_w[k]),
			.carry_i (carry_w[k]),
			.rank_i  (rank_w[k]),
			.ctl_o   (ctl_w[k+1]),
			.key_o   (key_w[k+1]),
			.carry_o (carry_w[k+1]),
			.rank_o  (rank_w[k+1])
		);
	end

	// output register: drop restart items, force rank to zero for bad items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl_w[MAX_ITEMS].valid && !ctl_w[MAX_ITEMS].restart;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rank_q <= ctl_w[MAX_ITEMS].bad ? '0 : rank_w[MAX_ITEMS];
			bad_q  <= ctl_w[MAX_ITEMS].bad;
		end
	end

	assign out_valid = out_valid_q;
	assign rank      = rank_q;
	assign bad_item  = bad_q;

endmodule
`default_nettype wire

FILE: hdl/mtf_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Move-to-front rank checker
// Port-level assertions on the result channel and the flow control.
// ---------------------------------------------------------------------------
module mtf_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_ready,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic [mtf_pkg::RANK_W-1:0] rank,
	input wire logic                       bad_item
);
	import mtf_pkg::*;

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a bad item always reports rank zero
	a_bad_rank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_item |-> rank == '0)
		else $error("bad item with non-zero rank");

	// input side is ready exactly when the output can move
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	// no result straight after reset
	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result offered out of reset");

endmodule

bind move_to_front_rank mtf_checker u_mtf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.rank      (rank),
	.bad_item  (bad_item)
);
`default_nettype wire

FILE: bench/tb_move_to_front_rank.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Move-to-front rank testbench
// Drives access and restart items into the move-to-front block and keeps its
// own copy of the ordered list. Every access gives an expected rank and bad
// flag, which are compared with the results in arrival order. The run covers
// directed corner cases, random phases with different idling on each side,
// several item_count settings and a long output stall that fills the chain.
// ---------------------------------------------------------------------------
module tb_move_to_front_rank;

	import mtf_pkg::*;

	localparam int MAX_ITEMS   = 256;
	// the chain is MAX_ITEMS cells long plus the output register
	localparam int SETTLE      = MAX_ITEMS + 40;
	localparam int HOLD_CYCLES = 800;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic              bad;
	} rank_result_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_ready;
	logic              mode       = MODE_ACCESS;
	logic [ITEM_W-1:0] item       = '0;
	logic              out_valid;
	logic              out_ready  = 1'b0;
	logic [RANK_W-1:0] rank;
	logic              bad_item;
	logic              cfg_valid  = 1'b0;
	logic              cfg_ready;
	logic [ITEM_W-1:0] item_count = ITEM_COUNT_RST;

	// own copy of the list and of the register
	logic [ITEM_W-1:0] mtf_order [MAX_ITEMS];
	int unsigned       mtf_count;
	rank_result_t      expected_ranks[$];

	int          err_count     = 0;
	int unsigned cycle_count   = 0;
	int unsigned tx_idle_pct   = 0;
	int unsigned rx_idle_pct   = 0;
	bit          stall_request = 1'b0;
	int unsigned stall_left    = 0;

	move_to_front_rank #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.item      (item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rank      (rank),
		.bad_item  (bad_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.item_count(item_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort the run if it hangs: a lost result or a stuck handshake ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Put the list back in ascending order: position k holds item k+1.
	function automatic void mtf_restore();
		for (int k = 0; k < MAX_ITEMS; k++)
			mtf_order[k] = ITEM_W'(k + 1);
	endfunction

	function automatic int unsigned effective_count();
		return (mtf_count > MAX_ITEMS) ? MAX_ITEMS : mtf_count;
	endfunction

	// Apply one accepted item to the list and queue the result it causes.
	task automatic predict_rank(input logic m, input logic [ITEM_W-1:0] it);
		int           pos;
		rank_result_t res;
		pos = 0;
		if (m == MODE_RESTART) begin
			mtf_restore();
			return;
		end
		if (it == 0 || it > effective_count()) begin
			// bad item: flag it, rank 0, list untouched
			res.rank = '0;
			res.bad  = 1'b1;
			expected_ranks = {expected_ranks, res};
			return;
		end
		while (pos < MAX_ITEMS && mtf_order[pos] != it)
			pos++;
		// shift everything ahead of it down one place, then put it in front
		for (int k = pos; k > 0; k--)
			mtf_order[k] = mtf_order[k-1];
		mtf_order[0] = it;
		res.rank = (pos > RANK_MAX) ? RANK_W'(RANK_MAX) : RANK_W'(pos);
		res.bad  = 1'b0;
		expected_ranks = {expected_ranks, res};
	endtask

	// ------------------------------------------------------------------
	// Receiver and result check
	// ------------------------------------------------------------------

	// Drive out_ready: a requested long hold-off wins, otherwise idle at
	// random by the current percentage.
	always @(posedge clk) begin
		if (stall_request) begin
			stall_left    = HOLD_CYCLES;
			stall_request = 1'b0;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
		end
	end

	// Values seen here are those before the edge, since every input is
	// driven with nonblocking assignments.
	always @(posedge clk) begin
		rank_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (expected_ranks.size() == 0) begin
				$error("unexpected result: rank %0d bad_item %0b", rank, bad_item);
				err_count++;
			end else begin
				exp_res = expected_ranks.pop_front();
				if (rank !== exp_res.rank) begin
					$error("rank: expected %0d, actual %0d", exp_res.rank, rank);
					err_count++;
				end
				if (bad_item !== exp_res.bad) begin
					$error("bad_item: expected %0b, actual %0b", exp_res.bad, bad_item);
					err_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Offer one item, idling first at random, and hold it until accepted.
	// Valid stays high on return so back-to-back items follow without a gap.
	task automatic send_item(input logic m, input logic [ITEM_W-1:0] it);
		if ($urandom_range(99, 0) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99, 0) < tx_idle_pct);
		end
		in_valid <= 1'b1;
		mode     <= m;
		item     <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_rank(m, it);
	endtask

	// Stop offering, wait for every outstanding result, then let any
	// restart still in the chain run out.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_ranks.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write item_count; only ever called with the block idle.
	task automatic write_item_count(input logic [ITEM_W-1:0] value);
		cfg_valid  <= 1'b1;
		item_count <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		mtf_count  = value;
	endtask

	// Mostly well-formed accesses, some near the front of the list for small
	// ranks, plus a sprinkling of restarts and bad items.
	task automatic random_item(output logic m, output logic [ITEM_W-1:0] it);
		int unsigned sel;
		int unsigned eff;
		sel = $urandom_range(99, 0);
		eff = effective_count();
		m   = MODE_ACCESS;
		if (sel < 3) begin
			m  = MODE_RESTART;
			it = ITEM_W'($urandom_range(MAX_ITEMS, 0));
		end else if (sel < 9) begin
			if (eff < MAX_ITEMS && $urandom_range(1, 0) == 1)
				it = ITEM_W'($urandom_range(MAX_ITEMS, eff + 1));
			else
				it = '0;
		end else if (sel < 30 && mtf_order[$urandom_range(3, 0)] <= eff) begin
			it = mtf_order[$urandom_range(3, 0)];
			if (it > eff)
				it = mtf_order[0];
		end else begin
			it = ITEM_W'($urandom_range(eff, 1));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Corner cases: both ends of the list, repeat access, restart, item 0,
	// count changes without restart, zero count and a count above capacity.
	task automatic test_directed();
		tx_idle_pct = 12;
		rx_idle_pct = 73;
		write_item_count(9'd256);
		send_item(MODE_ACCESS, 9'd1);
		send_item(MODE_ACCESS, 9'd256);
		send_item(MODE_ACCESS, 9'd256);
		send_item(MODE_ACCESS, 9'd128);
		send_item(MODE_ACCESS, 9'd0);
		send_item(MODE_ACCESS, 9'd255);
		send_item(MODE_RESTART, 9'd256);
		send_item(MODE_ACCESS, 9'd256);
		send_item(MODE_ACCESS, 9'd1);
		send_item(MODE_RESTART, 9'd0);
		send_item(MODE_ACCESS, 9'd2);
		drain();
		// shrink the count with the list left as it is
		write_item_count(9'd1);
		send_item(MODE_ACCESS, 9'd1);
		send_item(MODE_ACCESS, 9'd2);
		send_item(MODE_ACCESS, 9'd256);
		drain();
		// zero count: every access is bad
		write_item_count(9'd0);
		send_item(MODE_ACCESS, 9'd1);
		send_item(MODE_ACCESS, 9'd0);
		drain();
		// count above capacity acts as the full list
		write_item_count(9'd511);
		send_item(MODE_ACCESS, 9'd256);
		send_item(MODE_ACCESS, 9'd255);
		send_item(MODE_RESTART, 9'd128);
		drain();
		write_item_count(9'd2);
		send_item(MODE_ACCESS, 9'd2);
		send_item(MODE_ACCESS, 9'd3);
		send_item(MODE_ACCESS, 9'd1);
	endtask

	// One random phase under a given count and idling on each side.
	task automatic test_random(input int n, input int unsigned tx_pct,
	                           input int unsigned rx_pct, input logic [ITEM_W-1:0] count);
		logic              m;
		logic [ITEM_W-1:0] it;
		drain();
		write_item_count(count);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int i = 0; i < n; i++) begin
			random_item(m, it);
			send_item(m, it);
		end
	endtask

	// Hold off the receiver long enough for the chain to fill and in_ready
	// to drop, while the sender keeps offering items without a break.
	task automatic test_backpressure(input int n);
		logic              m;
		logic [ITEM_W-1:0] it;
		drain();
		write_item_count(9'd256);
		tx_idle_pct   = 0;
		rx_idle_pct   = 0;
		stall_request = 1'b1;
		for (int i = 0; i < n; i++) begin
			random_item(m, it);
			send_item(m, it);
		end
	endtask

	initial begin
		mtf_restore();
		mtf_count = ITEM_COUNT_RST;
		// hold reset, then release it at an edge
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random(480, 12, 73, 9'd256);
		test_random(480, 73, 12, ITEM_W'($urandom_range(64, 2)));
		test_random(480, 0, 0, 9'd255);
		test_backpressure(500);
		drain();

		if (expected_ranks.size() != 0) begin
			$error("%0d results never arrived", expected_ranks.size());
			err_count++;
		end
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
